FILE: rtl/core/rzd_pkg.sv
`timescale 1ns / 1ps

package rzd_pkg;

  // Field widths
  localparam int HW_W    = 16;
  localparam int VAL_W   = 10;
  localparam int RUN_W   = 6;
  localparam int ADDR_W  = 7;
  localparam int BYTE_W  = 8;
  localparam int IDX_W   = 6;
  localparam int COEF_W  = 11;
  localparam int SLOT_W  = 3;
  localparam int POS_W   = 7;
  localparam int PROD_W  = 18;   // 10-bit signed value times 8-bit table entry
  localparam int WIDE_W  = 25;   // product times 6-bit scale, plus rounding

  // Defaults for top-level parameters
  localparam logic [HW_W-1:0] END_MARKER_DEF  = 16'hFE00;
  localparam int              QUEUE_DEPTH_DEF = 2;

  // Input request types
  localparam logic REQ_HALFWORD = 1'b0;
  localparam logic REQ_TABLE    = 1'b1;

  // Slot sequence: 0..1 use the colour table, 2..5 luminance
  localparam logic [SLOT_W-1:0] SLOT_LAST       = 3'd5;
  localparam logic [SLOT_W-1:0] SLOT_COLOR_LAST = 3'd1;
  localparam logic [IDX_W-1:0]  POS_LAST        = 6'd63;

  localparam logic signed [WIDE_W-1:0] COEF_MAX = 25'sd1023;
  localparam logic signed [WIDE_W-1:0] COEF_MIN = -25'sd1024;

  // Inverse zigzag: scan position to natural position
  localparam logic [IDX_W-1:0] NAT_OF_SCAN [64] = '{
     0,  1,  8, 16,  9,  2,  3, 10, 17, 24, 32, 25, 18, 11,  4,  5,
    12, 19, 26, 33, 40, 48, 41, 34, 27, 20, 13,  6,  7, 14, 21, 28,
    35, 42, 49, 56, 57, 50, 43, 36, 29, 22, 15, 23, 30, 37, 44, 51,
    58, 59, 52, 45, 38, 31, 39, 46, 53, 60, 61, 54, 47, 55, 62, 63
  };

  typedef enum logic [1:0] {
    CMD_WRITE,
    CMD_DC,
    CMD_AC,
    CMD_END
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t           kind;
    logic [HW_W-1:0]     halfword;
    logic [ADDR_W-1:0]   table_addr;
    logic [BYTE_W-1:0]   table_byte;
  } cmd_t;

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_RUN,
    SEQ_PAD
  } seq_state_t;

  function automatic logic [IDX_W-1:0] nat_of_scan(input logic [IDX_W-1:0] p);
    return NAT_OF_SCAN[p];
  endfunction

  function automatic logic signed [COEF_W-1:0] clamp_coef(
    input logic signed [WIDE_W-1:0] x
  );
    logic signed [WIDE_W-1:0] y;
    y = x;
    if (x > COEF_MAX) y = COEF_MAX;
    if (x < COEF_MIN) y = COEF_MIN;
    return y[COEF_W-1:0];
  endfunction

endpackage

FILE: rtl/core/rzd_in_if.sv
`timescale 1ns / 1ps

interface rzd_in_if;
  logic                        valid;
  logic                        ready;
  logic                        req_type;
  logic [rzd_pkg::HW_W-1:0]    halfword;
  logic [rzd_pkg::ADDR_W-1:0]  table_addr;
  logic [rzd_pkg::BYTE_W-1:0]  table_byte;

  modport source (output valid, req_type, halfword, table_addr, table_byte, input ready);
  modport sink   (input valid, req_type, halfword, table_addr, table_byte, output ready);
endinterface

FILE: rtl/core/rzd_out_if.sv
`timescale 1ns / 1ps

interface rzd_out_if;
  logic                               valid;
  logic                               ready;
  logic [rzd_pkg::IDX_W-1:0]          coef_index;
  logic signed [rzd_pkg::COEF_W-1:0]  coef_value;
  logic [rzd_pkg::SLOT_W-1:0]         block_slot;
  logic                               last;

  modport source (output valid, coef_index, coef_value, block_slot, last, input ready);
  modport sink   (input valid, coef_index, coef_value, block_slot, last, output ready);
endinterface

FILE: rtl/core/rzd_front.sv
`timescale 1ns / 1ps

// Accepts input transactions, tracks block framing and turns each
// transaction into a command for the back end.
module rzd_front #(
  parameter logic [rzd_pkg::HW_W-1:0] END_MARKER = rzd_pkg::END_MARKER_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  rzd_in_if.sink         in_ch,
  input  logic           q_full,
  output logic           q_push,
  output rzd_pkg::cmd_t  q_cmd
);

  logic in_block_r, in_block_nxt;
  logic accept;
  logic is_end;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign is_end      = (in_ch.halfword == END_MARKER);

  // Classify
  always_comb begin
    in_block_nxt        = in_block_r;
    q_push              = 1'b0;
    q_cmd.kind          = rzd_pkg::CMD_WRITE;
    q_cmd.halfword      = in_ch.halfword;
    q_cmd.table_addr    = in_ch.table_addr;
    q_cmd.table_byte    = in_ch.table_byte;
    if (accept) begin
      if (in_ch.req_type == rzd_pkg::REQ_TABLE) begin
        q_push = 1'b1;
      end else if (!in_block_r) begin
        // end marker outside a block is dropped
        if (!is_end) begin
          q_push       = 1'b1;
          q_cmd.kind   = rzd_pkg::CMD_DC;
          in_block_nxt = 1'b1;
        end
      end else if (is_end) begin
        q_push       = 1'b1;
        q_cmd.kind   = rzd_pkg::CMD_END;
        in_block_nxt = 1'b0;
      end else begin
        q_push     = 1'b1;
        q_cmd.kind = rzd_pkg::CMD_AC;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_block_r <= 1'b0;
    end else begin
      in_block_r <= in_block_nxt;
    end
  end

endmodule

FILE: rtl/core/rzd_cmd_queue.sv
`timescale 1ns / 1ps

// Small command FIFO between front and back end.
module rzd_cmd_queue #(
  parameter int DEPTH = rzd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  rzd_pkg::cmd_t  push_cmd,
  input  logic           pop,
  output logic           full,
  output logic           not_empty,
  output rzd_pkg::cmd_t  head_cmd
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  rzd_pkg::cmd_t    slots_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign full      = (cnt_r == CNT_W'(DEPTH));
  assign not_empty = (cnt_r != '0);
  assign head_cmd  = slots_r[rd_ptr_r];

  // Pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

FILE: rtl/core/rzd_back.sv
`timescale 1ns / 1ps

// Executes commands: table writes, run expansion, end padding, and the
// dequantization pipeline (table read, v*q, *scale with rounding and clamp).
module rzd_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           color_mode,
  input  logic           cmd_valid,
  input  rzd_pkg::cmd_t  cmd,
  output logic           cmd_pop,
  rzd_out_if.source      out_ch
);

  localparam int HW_W   = rzd_pkg::HW_W;
  localparam int VAL_W  = rzd_pkg::VAL_W;
  localparam int RUN_W  = rzd_pkg::RUN_W;
  localparam int IDX_W  = rzd_pkg::IDX_W;
  localparam int POS_W  = rzd_pkg::POS_W;
  localparam int SLOT_W = rzd_pkg::SLOT_W;
  localparam int PROD_W = rzd_pkg::PROD_W;
  localparam int WIDE_W = rzd_pkg::WIDE_W;
  localparam int ADDR_W = rzd_pkg::ADDR_W;
  localparam int BYTE_W = rzd_pkg::BYTE_W;

  // Quantization store
  logic [BYTE_W-1:0] qmem [2**ADDR_W];
  logic              mem_we;
  logic [ADDR_W-1:0] rd_addr;
  logic [BYTE_W-1:0] q_rd_r;

  // Sequencer state
  rzd_pkg::seq_state_t state_r, state_nxt;
  logic [POS_W-1:0]    pos_r, pos_nxt;
  logic [RUN_W-1:0]    zeros_r, zeros_nxt;
  logic [VAL_W-1:0]    val_r, val_nxt;
  logic [RUN_W-1:0]    scale_r, scale_nxt;
  logic [SLOT_W-1:0]   slot_r, slot_nxt;

  // Issue of one coefficient into the pipeline
  logic              adv;
  logic              issue;
  logic [IDX_W-1:0]  iss_pos;
  logic [VAL_W-1:0]  iss_val;
  logic [RUN_W-1:0]  iss_scale;
  logic [IDX_W-1:0]  iss_idx;
  logic              use_color;

  // Stage 1: table data returns
  logic              s1_v_r;
  logic [IDX_W-1:0]  s1_idx_r;
  logic [VAL_W-1:0]  s1_val_r;
  logic              s1_dc_r;
  logic [RUN_W-1:0]  s1_scale_r;
  logic [SLOT_W-1:0] s1_slot_r;
  logic              s1_last_r;

  // Stage 2: v*q
  logic signed [PROD_W-1:0] p1;
  logic                     s2_v_r;
  logic signed [PROD_W-1:0] s2_prod_r;
  logic [IDX_W-1:0]         s2_idx_r;
  logic [VAL_W-1:0]         s2_val_r;
  logic                     s2_dc_r;
  logic [RUN_W-1:0]         s2_scale_r;
  logic [SLOT_W-1:0]        s2_slot_r;
  logic                     s2_last_r;

  // Stage 3: scale, round toward zero, clamp
  logic signed [WIDE_W-1:0] prod_wide;
  logic signed [WIDE_W-1:0] p2;
  logic signed [WIDE_W-1:0] rnd;
  logic signed [WIDE_W-1:0] ac_q;
  logic signed [WIDE_W-1:0] dbl;
  logic signed [WIDE_W-1:0] sel;
  logic                     out_valid_r;
  logic [IDX_W-1:0]         out_idx_r;
  logic signed [rzd_pkg::COEF_W-1:0] out_val_r;
  logic [SLOT_W-1:0]        out_slot_r;
  logic                     out_last_r;

  assign adv = !out_valid_r || out_ch.ready;

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    pos_nxt   = pos_r;
    zeros_nxt = zeros_r;
    val_nxt   = val_r;
    scale_nxt = scale_r;
    slot_nxt  = slot_r;
    cmd_pop   = 1'b0;
    mem_we    = 1'b0;
    issue     = 1'b0;
    iss_pos   = pos_r[IDX_W-1:0];
    iss_val   = '0;
    iss_scale = scale_r;
    case (state_r)
      rzd_pkg::SEQ_IDLE: begin
        if (cmd_valid) begin
          case (cmd.kind)
            rzd_pkg::CMD_WRITE: begin
              cmd_pop = 1'b1;
              mem_we  = 1'b1;
            end
            rzd_pkg::CMD_DC: begin
              if (adv) begin
                cmd_pop   = 1'b1;
                issue     = 1'b1;
                iss_pos   = '0;
                iss_val   = cmd.halfword[VAL_W-1:0];
                iss_scale = cmd.halfword[HW_W-1:VAL_W];
                scale_nxt = cmd.halfword[HW_W-1:VAL_W];
                pos_nxt   = POS_W'(1);
              end
            end
            rzd_pkg::CMD_AC: begin
              cmd_pop   = 1'b1;
              zeros_nxt = cmd.halfword[HW_W-1:VAL_W];
              val_nxt   = cmd.halfword[VAL_W-1:0];
              state_nxt = rzd_pkg::SEQ_RUN;
            end
            rzd_pkg::CMD_END: begin
              cmd_pop   = 1'b1;
              state_nxt = rzd_pkg::SEQ_PAD;
            end
            default: begin
              cmd_pop = 1'b1;
            end
          endcase
        end
      end
      rzd_pkg::SEQ_RUN: begin
        // zeros of the run first, then the value; past the block end nothing issues
        if (adv) begin
          if (zeros_r != '0) begin
            zeros_nxt = zeros_r - 1'b1;
          end else begin
            iss_val   = val_r;
            state_nxt = rzd_pkg::SEQ_IDLE;
          end
          if (!pos_r[POS_W-1]) begin
            issue   = 1'b1;
            pos_nxt = pos_r + 1'b1;
          end
        end
      end
      rzd_pkg::SEQ_PAD: begin
        if (pos_r[POS_W-1]) begin
          // block closes
          pos_nxt   = '0;
          state_nxt = rzd_pkg::SEQ_IDLE;
          if (!color_mode) begin
            slot_nxt = '0;
          end else if (slot_r >= rzd_pkg::SLOT_LAST) begin
            slot_nxt = '0;
          end else begin
            slot_nxt = slot_r + 1'b1;
          end
        end else if (adv) begin
          issue   = 1'b1;
          pos_nxt = pos_r + 1'b1;
        end
      end
      default: begin
        state_nxt = rzd_pkg::SEQ_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rzd_pkg::SEQ_IDLE;
      pos_r   <= '0;
      scale_r <= '0;
      slot_r  <= '0;
    end else begin
      state_r <= state_nxt;
      pos_r   <= pos_nxt;
      scale_r <= scale_nxt;
      slot_r  <= slot_nxt;
    end
  end

  always_ff @(posedge clk) begin
    zeros_r <= zeros_nxt;
    val_r   <= val_nxt;
  end

  // Table address for the issued coefficient
  assign iss_idx   = (iss_scale == '0) ? iss_pos : rzd_pkg::nat_of_scan(iss_pos);
  assign use_color = color_mode && (slot_r <= rzd_pkg::SLOT_COLOR_LAST);
  assign rd_addr   = {use_color, iss_idx};

  // Store write and registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      qmem[cmd.table_addr] <= cmd.table_byte;
    end
    if (adv) begin
      q_rd_r <= qmem[rd_addr];
    end
  end

  // Stage 1
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_idx_r   <= iss_idx;
      s1_val_r   <= iss_val;
      s1_dc_r    <= (iss_pos == '0);
      s1_scale_r <= iss_scale;
      s1_slot_r  <= color_mode ? slot_r : '0;
      s1_last_r  <= (iss_pos == rzd_pkg::POS_LAST);
    end
  end

  // Stage 2: signed value times unsigned table entry
  assign p1 = PROD_W'($signed(s1_val_r)) * PROD_W'($signed({1'b0, q_rd_r}));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (adv) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_prod_r  <= p1;
      s2_idx_r   <= s1_idx_r;
      s2_val_r   <= s1_val_r;
      s2_dc_r    <= s1_dc_r;
      s2_scale_r <= s1_scale_r;
      s2_slot_r  <= s1_slot_r;
      s2_last_r  <= s1_last_r;
    end
  end

  // Stage 3: AC is (p1*scale + 4) / 8 truncated toward zero
  assign prod_wide = WIDE_W'(s2_prod_r);
  assign p2        = prod_wide * $signed({{(WIDE_W-RUN_W){1'b0}}, s2_scale_r});
  assign rnd       = p2 + WIDE_W'(4);
  assign ac_q      = (rnd + (rnd[WIDE_W-1] ? WIDE_W'(7) : WIDE_W'(0))) >>> 3;
  assign dbl       = WIDE_W'($signed(s2_val_r)) <<< 1;

  always_comb begin
    if (s2_scale_r == '0) begin
      sel = dbl;
    end else if (s2_dc_r) begin
      sel = prod_wide;
    end else begin
      sel = ac_q;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_idx_r  <= s2_idx_r;
      out_val_r  <= rzd_pkg::clamp_coef(sel);
      out_slot_r <= s2_slot_r;
      out_last_r <= s2_last_r;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.coef_index = out_idx_r;
  assign out_ch.coef_value = out_val_r;
  assign out_ch.block_slot = out_slot_r;
  assign out_ch.last       = out_last_r;

endmodule

FILE: rtl/core/rle_zigzag_dequant_block_decoder.sv
`timescale 1ns / 1ps

// Channel   | Port                   | Direction | Transaction
// ----------+------------------------+-----------+-------------------------------
// input     | in_ch (rzd_in_if)      | sink      | halfword or table byte write
// result    | out_ch (rzd_out_if)    | source    | one dequantized coefficient
// config    | cfg_we / cfg_wdata     | in        | color_mode write, no handshake
//
// A table write or DC halfword runs from idle; an AC halfword loads, then steps
// through its zeros and then its value (positions past 63 dropped); an end marker
// pads then closes the block. A coefficient passes the table read, v*q and *scale
// registers after issue. Reset clears framing, position, scale, slot, queue and
// pipeline valids, not the quantization store. A stall on out_ch freezes the
// pipeline and issue; in_ch accepts until the queue (2 entries by default) fills.
module rle_zigzag_dequant_block_decoder #(
  parameter logic [rzd_pkg::HW_W-1:0] END_MARKER  = rzd_pkg::END_MARKER_DEF,
  parameter int                       QUEUE_DEPTH = rzd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  rzd_in_if.sink      in_ch,
  rzd_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic        cfg_wdata
);

  logic          color_mode_r;
  logic          q_push;
  logic          q_pop;
  logic          q_full;
  logic          q_not_empty;
  rzd_pkg::cmd_t q_push_cmd;
  rzd_pkg::cmd_t q_head_cmd;

  // Mode register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_mode_r <= 1'b0;
    end else if (cfg_we) begin
      color_mode_r <= cfg_wdata;
    end
  end

  rzd_front #(
    .END_MARKER (END_MARKER)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_cmd  (q_push_cmd)
  );

  rzd_cmd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_cmd  (q_push_cmd),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head_cmd  (q_head_cmd)
  );

  rzd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .color_mode (color_mode_r),
    .cmd_valid  (q_not_empty),
    .cmd        (q_head_cmd),
    .cmd_pop    (q_pop),
    .out_ch     (out_ch)
  );

  // Checks
  a_last_at_63: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.last |-> out_ch.coef_index == rzd_pkg::POS_LAST)
    else $error("last flagged away from position 63");

  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.block_slot <= rzd_pkg::SLOT_LAST)
    else $error("block slot out of range");

  a_mono_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !color_mode_r |-> out_ch.block_slot == '0)
    else $error("nonzero slot in mono mode");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full || q_pop)
    else $error("command queue overflow");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid)
    else $error("result valid right after reset");

endmodule

FILE: tb/rzd_coef_checker.sv
`timescale 1ns / 1ps

// Watches both channels and the mode register, decodes every accepted input
// transaction into the coefficients it should cause, and compares them in
// order with the result transactions.
module rzd_coef_checker (
  input  logic clk,
  input  logic rst_n,
  rzd_in_if    in_mon,
  rzd_out_if   out_mon,
  input  logic cfg_we,
  input  logic cfg_wdata,
  output int   fail_count,
  output int   pending
);

  localparam int PRINT_LIMIT = 100;

  typedef struct {
    logic [rzd_pkg::IDX_W-1:0]         index;
    logic signed [rzd_pkg::COEF_W-1:0] value;
    logic [rzd_pkg::SLOT_W-1:0]        slot;
    logic                              last;
  } coef_t;

  // Decoder state as seen from the stream
  logic [rzd_pkg::BYTE_W-1:0] quant_tbl [128];
  logic [rzd_pkg::POS_W-1:0]  scan_pos;
  logic [rzd_pkg::RUN_W-1:0]  blk_scale;
  logic [rzd_pkg::SLOT_W-1:0] mb_slot;
  logic                       blk_open;
  logic                       colour_on;
  int                         zz_nat [64];
  int                         fails = 0;
  coef_t                      coefs_due [$];

  // Scan order to natural order, walking the anti-diagonals
  initial begin
    int k;
    int r;
    k = 0;
    for (int d = 0; d < 15; d++) begin
      if (d % 2 == 1) begin
        for (r = (d > 7) ? d - 7 : 0; r <= ((d < 7) ? d : 7); r++) begin
          zz_nat[k] = r * 8 + d - r;
          k++;
        end
      end else begin
        for (r = (d < 7) ? d : 7; r >= ((d > 7) ? d - 7 : 0); r--) begin
          zz_nat[k] = r * 8 + d - r;
          k++;
        end
      end
    end
  end

  function automatic int sext10(input logic [rzd_pkg::HW_W-1:0] w);
    return w[rzd_pkg::VAL_W-1] ? int'(w[rzd_pkg::VAL_W-1:0]) - 1024
                               : int'(w[rzd_pkg::VAL_W-1:0]);
  endfunction

  // One coefficient at the current scan position; nothing past position 63
  function automatic void emit_coef(input int v);
    int    p;
    int    base;
    int    prod;
    coef_t c;
    if (scan_pos >= 64) return;
    p = int'(scan_pos);
    scan_pos = scan_pos + 1'b1;
    base = (colour_on && mb_slot < 2) ? 64 : 0;
    if (blk_scale == '0) begin
      c.index = rzd_pkg::IDX_W'(p);
      prod = v * 2;
    end else begin
      c.index = rzd_pkg::IDX_W'(zz_nat[p]);
      if (p == 0) prod = v * int'(quant_tbl[base]);
      else prod = (v * int'(quant_tbl[base + zz_nat[p]]) * int'(blk_scale) + 4) / 8;
    end
    if (prod > 1023) prod = 1023;
    if (prod < -1024) prod = -1024;
    c.value = rzd_pkg::COEF_W'(prod);
    c.slot  = colour_on ? mb_slot : '0;
    c.last  = (p == 63);
    coefs_due = {coefs_due, c};
  endfunction

  function automatic void decode_item(input logic req,
                                      input logic [rzd_pkg::HW_W-1:0] hw,
                                      input logic [rzd_pkg::ADDR_W-1:0] addr,
                                      input logic [rzd_pkg::BYTE_W-1:0] data);
    int run;
    if (req == rzd_pkg::REQ_TABLE) begin
      quant_tbl[addr] = data;
      return;
    end
    if (!blk_open) begin
      // a marker at a block start is skipped
      if (hw == rzd_pkg::END_MARKER_DEF) return;
      blk_scale = hw[rzd_pkg::HW_W-1:rzd_pkg::VAL_W];
      scan_pos  = '0;
      blk_open  = 1'b1;
      emit_coef(sext10(hw));
    end else if (hw == rzd_pkg::END_MARKER_DEF) begin
      // pad with zeros, close, advance the macroblock slot in colour mode
      while (scan_pos < 64) emit_coef(0);
      blk_open = 1'b0;
      scan_pos = '0;
      if (colour_on) mb_slot = (mb_slot >= rzd_pkg::SLOT_LAST) ? '0 : mb_slot + 1'b1;
      else mb_slot = '0;
    end else begin
      run = int'(hw[rzd_pkg::HW_W-1:rzd_pkg::VAL_W]);
      for (int i = 0; i < run; i++) emit_coef(0);
      emit_coef(sext10(hw));
    end
  endfunction

  always @(posedge clk) begin
    coef_t want;
    if (!rst_n) begin
      scan_pos  = '0;
      blk_scale = '0;
      mb_slot   = '0;
      blk_open  = 1'b0;
      colour_on = 1'b0;
      coefs_due.delete();
    end else begin
      // compare first: a result never comes from an input of the same edge
      if (out_mon.valid && out_mon.ready) begin
        if (coefs_due.size() == 0) begin
          fails++;
          if (fails <= PRINT_LIMIT)
            $display("%0t: unexpected coefficient idx=%0d val=%0d slot=%0d last=%0b",
                     $time, out_mon.coef_index, out_mon.coef_value,
                     out_mon.block_slot, out_mon.last);
        end else begin
          want = coefs_due[0];
          coefs_due.delete(0);
          if (out_mon.coef_index !== want.index || out_mon.coef_value !== want.value ||
              out_mon.block_slot !== want.slot || out_mon.last !== want.last) begin
            fails++;
            if (fails <= PRINT_LIMIT)
              $display("%0t: mismatch expected idx=%0d val=%0d slot=%0d last=%0b, %s",
                       $time, want.index, want.value, want.slot, want.last,
                       $sformatf("actual idx=%0d val=%0d slot=%0d last=%0b",
                                 out_mon.coef_index, out_mon.coef_value,
                                 out_mon.block_slot, out_mon.last));
          end
        end
      end
      if (in_mon.valid && in_mon.ready)
        decode_item(in_mon.req_type, in_mon.halfword, in_mon.table_addr, in_mon.table_byte);
      if (cfg_we) colour_on = cfg_wdata;
    end
    fail_count <= fails;
    pending    <= coefs_due.size();
  end

endmodule

FILE: tb/tb_rle_zigzag_dequant_block_decoder.sv
`timescale 1ns / 1ps

module tb_rle_zigzag_dequant_block_decoder;

  localparam int   RESET_CYCLES  = 12;
  localparam int   SETTLE_CYCLES = 400;
  localparam int   HOLD_CYCLES   = 300;
  localparam int   CYCLE_LIMIT   = 2_000_000;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic cfg_wdata;
  int   fail_total;
  int   left_count;
  int   cycle_cnt = 0;
  int   fed = 0;
  int   hold_req = 0;
  bit   rx_gaps = 1'b1;
  bit   tx_gaps = 1'b1;
  bit   paused = 1'b0;

  rzd_in_if  in_ch ();
  rzd_out_if out_ch ();

  rle_zigzag_dequant_block_decoder uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  rzd_coef_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_total),
    .pending    (left_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Timeout guard
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Result side: random stall bursts, plus one long hold-off on request
  initial begin
    int hold_done;
    hold_done = 0;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req != hold_done) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done++;
      end else if (rx_gaps && $urandom_range(0, 7) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
    end
  end

  function automatic logic [rzd_pkg::HW_W-1:0] mk_word(input int lead, input int val);
    return rzd_pkg::HW_W'(((lead & 63) << rzd_pkg::VAL_W) | (val & 1023));
  endfunction

  function automatic logic [rzd_pkg::BYTE_W-1:0] pick_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return rzd_pkg::BYTE_W'($urandom_range(0, 255));
    endcase
  endfunction

  // One input transaction; valid stays high unless a gap follows
  task automatic push_item(input logic req, input logic [rzd_pkg::HW_W-1:0] hw,
                           input logic [rzd_pkg::ADDR_W-1:0] addr,
                           input logic [rzd_pkg::BYTE_W-1:0] data);
    if (tx_gaps && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.req_type   <= req;
    in_ch.halfword   <= hw;
    in_ch.table_addr <= addr;
    in_ch.table_byte <= data;
    do @(posedge clk); while (!in_ch.ready);
    fed++;
  endtask

  // Unused fields get random content
  task automatic push_word(input logic [rzd_pkg::HW_W-1:0] hw);
    push_item(rzd_pkg::REQ_HALFWORD, hw, rzd_pkg::ADDR_W'($urandom_range(0, 127)),
              pick_byte());
  endtask

  task automatic push_table(input logic [rzd_pkg::ADDR_W-1:0] addr,
                            input logic [rzd_pkg::BYTE_W-1:0] data);
    push_item(rzd_pkg::REQ_TABLE, rzd_pkg::HW_W'($urandom_range(0, 65535)), addr, data);
  endtask

  task automatic wait_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (left_count != 0);
  endtask

  // Mode write only with the decoder drained and quiet
  task automatic set_colour(input logic mode);
    wait_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= mode;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Mostly well-formed blocks; some left open or with table writes inside
  task automatic send_block();
    int sc;
    int n_ac;
    int run;
    if ($urandom_range(0, 5) == 0) sc = 0;
    else if ($urandom_range(0, 5) == 0) sc = 63;
    else sc = $urandom_range(1, 63);
    push_word(mk_word(sc, $urandom_range(0, 1023)));
    n_ac = $urandom_range(0, 7);
    repeat (n_ac) begin
      if ($urandom_range(0, 11) == 0)
        push_table(rzd_pkg::ADDR_W'($urandom_range(0, 127)), pick_byte());
      run = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 4);
      push_word(mk_word(run, $urandom_range(0, 1023)));
    end
    if ($urandom_range(0, 11) != 0) push_word(rzd_pkg::END_MARKER_DEF);
  endtask

  task automatic random_unit();
    if ($urandom_range(0, 9) < 8) begin
      send_block();
    end else begin
      case ($urandom_range(0, 2))
        0: push_table(rzd_pkg::ADDR_W'($urandom_range(0, 127)), pick_byte());
        1: push_word(rzd_pkg::HW_W'($urandom_range(0, 65535)));
        default: push_word(rzd_pkg::END_MARKER_DEF);
      endcase
    end
  endtask

  initial begin
    in_ch.valid      <= 1'b0;
    in_ch.req_type   <= rzd_pkg::REQ_HALFWORD;
    in_ch.halfword   <= '0;
    in_ch.table_addr <= '0;
    in_ch.table_byte <= '0;
    cfg_we           <= 1'b0;
    cfg_wdata        <= 1'b0;
    rst_n            <= 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Fill both quantization tables before any block reads them
    for (int a = 0; a < 128; a++)
      push_table(rzd_pkg::ADDR_W'(a), (a == 0 || a == 70) ? 8'hFF :
                 (a == 127) ? 8'h00 : rzd_pkg::BYTE_W'($urandom_range(0, 255)));

    // Zero scale: doubling of the largest and smallest values, padded by the marker
    push_word(mk_word(0, 511));
    push_word(mk_word(0, -512));
    push_word(rzd_pkg::END_MARKER_DEF);
    // marker with no block open is skipped
    push_word(rzd_pkg::END_MARKER_DEF);
    // max scale; long run overruns position 63, later words dropped,
    // marker on a full block closes without output
    push_word(mk_word(63, 511));
    push_word(mk_word(63, -1));
    push_word(mk_word(5, 100));
    push_word(rzd_pkg::END_MARKER_DEF);
    // table write inside a block, entry then used by the next AC word
    push_word(mk_word(1, 1));
    push_table(7'd2, 8'hFF);
    push_word(mk_word(4, 511));
    push_word(mk_word(0, -512));
    push_word(rzd_pkg::END_MARKER_DEF);

    // Colour: slots 0 and 1 on the colour table, slot 2 luminance
    set_colour(1'b1);
    push_word(mk_word(7, -1));
    push_word(mk_word(0, 511));
    push_word(rzd_pkg::END_MARKER_DEF);
    push_word(mk_word(32, -512));
    push_word(rzd_pkg::END_MARKER_DEF);
    push_word(mk_word(2, 300));
    // mode change with a block still open
    set_colour(1'b0);
    push_word(mk_word(3, -300));
    push_word(rzd_pkg::END_MARKER_DEF);

    // Colour phase with a long result-side hold-off at its start
    set_colour(1'b1);
    hold_req <= hold_req + 1;
    while (fed < 195) random_unit();

    // Mono phase with one full drain pause
    set_colour(1'b0);
    while (fed < 225) begin
      random_unit();
      if (!paused && fed >= 210) begin
        wait_results();
        paused = 1'b1;
      end
    end

    // Final colour phase, no idling on either side
    set_colour(1'b1);
    rx_gaps <= 1'b0;
    tx_gaps = 1'b0;
    while (fed < 255) random_unit();

    wait_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_total == 0 && left_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/rzd_pkg.sv
rtl/core/rzd_in_if.sv
rtl/core/rzd_out_if.sv
rtl/core/rzd_front.sv
rtl/core/rzd_cmd_queue.sv
rtl/core/rzd_back.sv
rtl/core/rle_zigzag_dequant_block_decoder.sv
tb/rzd_coef_checker.sv
tb/tb_rle_zigzag_dequant_block_decoder.sv
